// ===== design/lsrr_pkg.sv =====
package lsrr_pkg;

    // Word format
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MAG_WIDTH  = DATA_WIDTH - 1;

    // Courant factor register, unsigned Q1.16
    localparam int CFL_WIDTH = 17;
    localparam logic [CFL_WIDTH-1:0] CFL_RESET = 17'd58982;

    // Serial divider: dividend is |difference| << FRAC_BITS
    localparam int DIVD_W = DATA_WIDTH + 1 + FRAC_BITS;

    // Upwind sum saturates at 2^(63-FRAC_BITS)-1 (all ones in SUM_W bits)
    localparam int SUM_W = 63 - FRAC_BITS;

    // Shift-add multiplier and square root widths
    localparam int PROD_W  = 64;
    localparam int MPL_W   = DATA_WIDTH + 1;
    localparam int ROOT_W  = 32;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 3;
    localparam int CNT_W   = $clog2(DIVD_W);

    localparam logic [MAG_WIDTH-1:0] MAXV = {MAG_WIDTH{1'b1}};

    // Axis codes
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // Sign codes for +1 and 0
    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_ZERO = 2'b00;

endpackage

// ===== design/level_set_reinit_residual.sv =====
// Channel   Ports                                   Moves
// s_        s_valid / s_ready + 10 payload ports    one axis item per transfer
// m_        m_valid / m_ready + 4 payload ports     one node result per z item
// cfg_      cfg_we / cfg_wdata                      Courant factor, no wait
//
// One item at a time. An x or y item passes through the two bit-serial slope
// dividers (one quotient bit per cycle), the shift-add squarer and three control
// steps. A z item adds 32 square-root steps (two radicand bits per cycle) and,
// for a node that is not fixed, two shift-add products. Axis 3 items are taken
// and dropped. Reset is synchronous, active low, and needs no clearing pass. The
// result register lets the next item be taken while a result waits; the block
// stalls only at the end of a z item when that register is still full.
module level_set_reinit_residual (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [lsrr_pkg::CFL_WIDTH-1:0]        cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_axis,
    input  logic signed [lsrr_pkg::DATA_WIDTH-1:0] s_phi_center,
    input  logic signed [lsrr_pkg::DATA_WIDTH-1:0] s_phi_minus,
    input  logic signed [lsrr_pkg::DATA_WIDTH-1:0] s_phi_plus,
    input  logic [lsrr_pkg::MAG_WIDTH-1:0]        s_gap_minus,
    input  logic [lsrr_pkg::MAG_WIDTH-1:0]        s_gap_plus,
    input  logic [lsrr_pkg::MAG_WIDTH-1:0]        s_cell_width,
    input  logic                                  s_fixed_node,
    input  logic signed [1:0]                     s_sign_value,
    input  logic                                  s_last_node,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [lsrr_pkg::DATA_WIDTH-1:0] m_residual_update,
    output logic [lsrr_pkg::MAG_WIDTH-1:0]        m_local_magnitude,
    output logic [lsrr_pkg::MAG_WIDTH-1:0]        m_running_max,
    output logic                                  m_sweep_done
);
    import lsrr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_SEL, ST_MUL, ST_ACC, ST_SQRT, ST_MAG, ST_FIN
    } state_t;

    typedef enum logic [1:0] {MK_SQR, MK_DT, MK_RES} mul_kind_t;

    state_t    state_reg;
    mul_kind_t kind_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Configuration and accumulated node state
    logic [CFL_WIDTH-1:0]  cfl_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [DATA_WIDTH-1:0] min_w_reg;
    logic [MAG_WIDTH-1:0]  max_reg;

    // Item fields held for the duration of the work
    logic [1:0]           axis_reg;
    logic                 c_neg_reg;
    logic                 neg_a_reg, neg_b_reg, zero_a_reg, zero_b_reg;
    logic [MAG_WIDTH-1:0] den_a_reg, den_b_reg, cw_reg;
    logic                 fixed_reg, last_reg;
    logic [1:0]           sg_reg;

    // Dividers
    logic [DIVD_W-1:0]    divd_a_reg, divd_b_reg;
    logic [MAG_WIDTH-1:0] rem_a_reg, rem_b_reg, q_a_reg, q_b_reg;
    logic                 ovf_a_reg, ovf_b_reg;

    // Multiplier
    logic [PROD_W-1:0] acc_reg, mcand_reg;
    logic [MPL_W-1:0]  mpl_reg;

    // Square root
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  srem_reg;
    logic [ROOT_W-1:0] root_reg;

    // Result pieces
    logic                 ge_reg;
    logic [MAG_WIDTH-1:0] mag_reg, rm_reg;

    // Output register
    logic                         m_valid_reg;
    logic signed [DATA_WIDTH-1:0] res_out_reg;
    logic [MAG_WIDTH-1:0]         mag_out_reg, max_out_reg;
    logic                         done_out_reg;

    // Input-side differences
    logic signed [DATA_WIDTH:0] diff_a, diff_b;
    logic [DATA_WIDTH:0]        mag_a, mag_b;

    always_comb begin
        diff_a = {s_phi_center[DATA_WIDTH-1], s_phi_center}
               - {s_phi_minus[DATA_WIDTH-1], s_phi_minus};
        diff_b = {s_phi_plus[DATA_WIDTH-1], s_phi_plus}
               - {s_phi_center[DATA_WIDTH-1], s_phi_center};
        mag_a  = diff_a[DATA_WIDTH] ? (DATA_WIDTH+1)'(-diff_a) : diff_a;
        mag_b  = diff_b[DATA_WIDTH] ? (DATA_WIDTH+1)'(-diff_b) : diff_b;
    end

    // One restoring-division step per divider
    logic [DATA_WIDTH-1:0] r2_a, r2_b, rs_a, rs_b;
    logic                  qb_a, qb_b;
    logic [MAG_WIDTH-1:0]  rn_a, rn_b;

    always_comb begin
        r2_a = {rem_a_reg, divd_a_reg[DIVD_W-1]};
        r2_b = {rem_b_reg, divd_b_reg[DIVD_W-1]};
        qb_a = r2_a >= {1'b0, den_a_reg};
        qb_b = r2_b >= {1'b0, den_b_reg};
        rs_a = r2_a - {1'b0, den_a_reg};
        rs_b = r2_b - {1'b0, den_b_reg};
        rn_a = qb_a ? rs_a[MAG_WIDTH-1:0] : r2_a[MAG_WIDTH-1:0];
        rn_b = qb_b ? rs_b[MAG_WIDTH-1:0] : r2_b[MAG_WIDTH-1:0];
    end

    // Upwind selection from the saturated slopes
    logic [MAG_WIDTH-1:0] qa, qb, t1, t2, tsel;

    always_comb begin
        qa   = zero_a_reg ? '0 : (ovf_a_reg ? MAXV : q_a_reg);
        qb   = zero_b_reg ? '0 : (ovf_b_reg ? MAXV : q_b_reg);
        t1   = (neg_a_reg == c_neg_reg) ? qa : '0;
        t2   = (neg_b_reg != c_neg_reg) ? qb : '0;
        tsel = (t1 > t2) ? t1 : t2;
    end

    // Multiplier step
    logic [PROD_W-1:0] acc_step;
    assign acc_step = acc_reg + (mpl_reg[0] ? mcand_reg : '0);

    // Saturating sum of the new term
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   sum_new;
    always_comb begin
        sum_add = {1'b0, sum_reg} + {1'b0, acc_reg[FRAC_BITS +: SUM_W]};
        sum_new = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    end

    // Square-root step, two radicand bits per cycle
    logic [REM_W-1:0] srem2, trial, srem_sub;
    logic             sq_ge;
    always_comb begin
        srem2    = {srem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial    = {1'b0, root_reg, 2'b01};
        sq_ge    = srem2 >= trial;
        srem_sub = srem2 - trial;
    end

    // |root - 1.0|, saturated
    localparam logic [ROOT_W-1:0] ONE = ROOT_W'(1) << FRAC_BITS;
    logic              root_ge;
    logic [ROOT_W-1:0] mag_full;
    logic [MAG_WIDTH-1:0] mag_sat;
    always_comb begin
        root_ge  = root_reg >= ONE;
        mag_full = root_ge ? root_reg - ONE : ONE - root_reg;
        mag_sat  = mag_full[ROOT_W-1] ? MAXV : mag_full[MAG_WIDTH-1:0];
    end

    // Final signed update and running maximum
    logic                         res_neg;
    logic signed [DATA_WIDTH-1:0] res_val;
    logic [MAG_WIDTH-1:0]         max_new;
    always_comb begin
        res_neg = (sg_reg == SIGN_POS) ^ !ge_reg;
        if (fixed_reg || sg_reg == SIGN_ZERO) begin
            res_val = '0;
        end else if (res_neg) begin
            res_val = -$signed({1'b0, rm_reg});
        end else begin
            res_val = $signed({1'b0, rm_reg});
        end
        max_new = (!fixed_reg && mag_reg > max_reg) ? mag_reg : max_reg;
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // Sequencer, datapath registers and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            kind_reg    <= MK_SQR;
            cnt_reg     <= '0;
            cfl_reg     <= CFL_RESET;
            sum_reg     <= '0;
            min_w_reg   <= '1;
            max_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cfl_reg <= cfg_wdata;
            end
            // ST_FIN reloads the result register itself
            if (m_valid_reg && m_ready && state_reg != ST_FIN) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_axis != AXIS_NONE) begin
                        axis_reg   <= s_axis;
                        c_neg_reg  <= s_phi_center[DATA_WIDTH-1];
                        neg_a_reg  <= diff_a[DATA_WIDTH];
                        neg_b_reg  <= diff_b[DATA_WIDTH];
                        zero_a_reg <= (mag_a == '0);
                        zero_b_reg <= (mag_b == '0);
                        den_a_reg  <= s_gap_minus;
                        den_b_reg  <= s_gap_plus;
                        cw_reg     <= s_cell_width;
                        fixed_reg  <= s_fixed_node;
                        sg_reg     <= s_sign_value;
                        last_reg   <= s_last_node;
                        divd_a_reg <= {mag_a, {FRAC_BITS{1'b0}}};
                        divd_b_reg <= {mag_b, {FRAC_BITS{1'b0}}};
                        rem_a_reg  <= '0;
                        rem_b_reg  <= '0;
                        q_a_reg    <= '0;
                        q_b_reg    <= '0;
                        ovf_a_reg  <= 1'b0;
                        ovf_b_reg  <= 1'b0;
                        cnt_reg    <= '0;
                        state_reg  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_a_reg  <= rn_a;
                    rem_b_reg  <= rn_b;
                    ovf_a_reg  <= ovf_a_reg | q_a_reg[MAG_WIDTH-1];
                    ovf_b_reg  <= ovf_b_reg | q_b_reg[MAG_WIDTH-1];
                    q_a_reg    <= {q_a_reg[MAG_WIDTH-2:0], qb_a};
                    q_b_reg    <= {q_b_reg[MAG_WIDTH-2:0], qb_b};
                    divd_a_reg <= divd_a_reg << 1;
                    divd_b_reg <= divd_b_reg << 1;
                    cnt_reg    <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIVD_W - 1)) begin
                        state_reg <= ST_SEL;
                    end
                end
                ST_SEL: begin
                    acc_reg   <= '0;
                    mcand_reg <= PROD_W'(tsel);
                    mpl_reg   <= MPL_W'(tsel);
                    kind_reg  <= MK_SQR;
                    cnt_reg   <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    if (cnt_reg == CNT_W'(MPL_W - 1)) begin
                        cnt_reg <= '0;
                        unique case (kind_reg)
                            MK_SQR: begin
                                acc_reg   <= acc_step;
                                state_reg <= ST_ACC;
                            end
                            MK_DT: begin
                                // dt = cfl * width >> FRAC_BITS, then dt * |local|
                                acc_reg   <= '0;
                                mcand_reg <= PROD_W'(acc_step[FRAC_BITS +: MPL_W]);
                                mpl_reg   <= MPL_W'(mag_reg);
                                kind_reg  <= MK_RES;
                            end
                            MK_RES: begin
                                rm_reg    <= (acc_step[PROD_W-1:FRAC_BITS+MAG_WIDTH] != '0)
                                           ? MAXV : acc_step[FRAC_BITS +: MAG_WIDTH];
                                state_reg <= ST_FIN;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end else begin
                        acc_reg   <= acc_step;
                        mcand_reg <= mcand_reg << 1;
                        mpl_reg   <= mpl_reg >> 1;
                        cnt_reg   <= cnt_reg + 1'b1;
                    end
                end
                ST_ACC: begin
                    sum_reg <= sum_new;
                    if (axis_reg != AXIS_Z) begin
                        if ({1'b0, cw_reg} < min_w_reg) begin
                            min_w_reg <= {1'b0, cw_reg};
                        end
                        state_reg <= ST_IDLE;
                    end else begin
                        rad_reg   <= {1'b0, sum_new, {FRAC_BITS{1'b0}}};
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    srem_reg <= sq_ge ? srem_sub : srem2;
                    root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
                    rad_reg  <= rad_reg << 2;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                        state_reg <= ST_MAG;
                    end
                end
                ST_MAG: begin
                    ge_reg  <= root_ge;
                    cnt_reg <= '0;
                    if (fixed_reg) begin
                        mag_reg   <= '0;
                        rm_reg    <= '0;
                        state_reg <= ST_FIN;
                    end else begin
                        mag_reg   <= mag_sat;
                        acc_reg   <= '0;
                        mcand_reg <= PROD_W'(min_w_reg);
                        mpl_reg   <= MPL_W'(cfl_reg);
                        kind_reg  <= MK_DT;
                        state_reg <= ST_MUL;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        res_out_reg  <= res_val;
                        mag_out_reg  <= mag_reg;
                        max_out_reg  <= max_new;
                        done_out_reg <= last_reg;
                        sum_reg      <= '0;
                        min_w_reg    <= '1;
                        max_reg      <= last_reg ? '0 : max_new;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_residual_update = res_out_reg;
    assign m_local_magnitude = mag_out_reg;
    assign m_running_max     = max_out_reg;
    assign m_sweep_done      = done_out_reg;

endmodule

// ===== tb/level_set_reinit_residual_tb.sv =====
`timescale 1ns / 1ps

module level_set_reinit_residual_tb;
    import lsrr_pkg::*;

    typedef struct {
        logic [1:0]                  axis;
        logic signed [DATA_WIDTH-1:0] phi_center;
        logic signed [DATA_WIDTH-1:0] phi_minus;
        logic signed [DATA_WIDTH-1:0] phi_plus;
        logic [MAG_WIDTH-1:0]        gap_minus;
        logic [MAG_WIDTH-1:0]        gap_plus;
        logic [MAG_WIDTH-1:0]        cell_width;
        logic                        fixed_node;
        logic signed [1:0]           sign_value;
        logic                        last_node;
    } axis_item_t;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] residual_update;
        logic [MAG_WIDTH-1:0]        local_magnitude;
        logic [MAG_WIDTH-1:0]        running_max;
        logic                        sweep_done;
    } node_result_t;

    localparam longint unsigned SUM_LIMIT  = (64'd1 << SUM_W) - 1;
    localparam longint unsigned MAG_LIMIT  = (64'd1 << MAG_WIDTH) - 1;
    localparam longint unsigned WIDTH_INIT = (64'd1 << DATA_WIDTH) - 1;
    localparam longint unsigned UNIT_ONE   = 64'd1 << FRAC_BITS;
    localparam int              CYCLE_LIMIT = 2000000;
    localparam int              DRAIN_CYCLES = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFL_WIDTH-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_axis = AXIS_X;
    logic signed [DATA_WIDTH-1:0] s_phi_center = '0;
    logic signed [DATA_WIDTH-1:0] s_phi_minus = '0;
    logic signed [DATA_WIDTH-1:0] s_phi_plus = '0;
    logic [MAG_WIDTH-1:0] s_gap_minus = '0;
    logic [MAG_WIDTH-1:0] s_gap_plus = '0;
    logic [MAG_WIDTH-1:0] s_cell_width = '0;
    logic s_fixed_node = 1'b0;
    logic signed [1:0] s_sign_value = SIGN_ZERO;
    logic s_last_node = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [DATA_WIDTH-1:0] m_residual_update;
    logic [MAG_WIDTH-1:0] m_local_magnitude;
    logic [MAG_WIDTH-1:0] m_running_max;
    logic m_sweep_done;

    level_set_reinit_residual u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_axis            (s_axis),
        .s_phi_center      (s_phi_center),
        .s_phi_minus       (s_phi_minus),
        .s_phi_plus        (s_phi_plus),
        .s_gap_minus       (s_gap_minus),
        .s_gap_plus        (s_gap_plus),
        .s_cell_width      (s_cell_width),
        .s_fixed_node      (s_fixed_node),
        .s_sign_value      (s_sign_value),
        .s_last_node       (s_last_node),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_residual_update (m_residual_update),
        .m_local_magnitude (m_local_magnitude),
        .m_running_max     (m_running_max),
        .m_sweep_done      (m_sweep_done)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    axis_item_t   pending_items[$];
    node_result_t node_results_due[$];
    axis_item_t   driven_item;

    // Predictor state
    logic [CFL_WIDTH-1:0] courant;
    longint unsigned      upwind_acc;
    longint unsigned      narrow_width;
    longint unsigned      peak_magnitude;

    int send_idle_pct = 6;
    int recv_idle_pct = 82;
    int mismatch_count = 0;
    int items_sent = 0;
    int nodes_checked = 0;
    int sweeps_seen = 0;
    int fixed_seen = 0;
    int cycle_count = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Append one item to the stimulus queue
    task automatic enqueue_item(input axis_item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    // Saturating Q-format slope: (diff << FRAC_BITS) / gap
    function automatic longint slope_q(input longint diff, input longint unsigned gap);
        longint unsigned mag;
        longint unsigned q;
        mag = (diff < 0) ? longint'(-diff) : longint'(diff);
        if (mag == 0)
            return 0;
        if (gap == 0) begin
            q = MAG_LIMIT;
        end else begin
            q = (mag << FRAC_BITS) / gap;
            if (q > MAG_LIMIT)
                q = MAG_LIMIT;
        end
        return (diff < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Advance the predictor by one accepted item
    task automatic predict_node(input axis_item_t it);
        longint a, b, cv;
        longint unsigned t1, t2, tmax, term, root, mag, dt, res_mag;
        logic [127:0] prod;
        longint res;
        node_result_t r;
        if (it.axis == AXIS_NONE)
            return;
        cv = longint'(it.phi_center);
        a = slope_q(cv - longint'(it.phi_minus), 64'(it.gap_minus));
        b = slope_q(longint'(it.phi_plus) - cv, 64'(it.gap_plus));
        if (cv >= 0) begin
            t1 = (a > 0) ? a : 0;
            t2 = (b < 0) ? -b : 0;
        end else begin
            t1 = (a < 0) ? -a : 0;
            t2 = (b > 0) ? b : 0;
        end
        tmax = (t1 > t2) ? t1 : t2;
        term = (tmax * tmax) >> FRAC_BITS;
        if (term > SUM_LIMIT)
            term = SUM_LIMIT;
        upwind_acc = (SUM_LIMIT - upwind_acc < term) ? SUM_LIMIT : upwind_acc + term;
        if (it.axis != AXIS_Z) begin
            if (64'(it.cell_width) < narrow_width)
                narrow_width = 64'(it.cell_width);
            return;
        end
        // z closes the node
        root = floor_sqrt(upwind_acc << FRAC_BITS);
        mag = (root >= UNIT_ONE) ? root - UNIT_ONE : UNIT_ONE - root;
        if (mag > MAG_LIMIT)
            mag = MAG_LIMIT;
        if (it.fixed_node) begin
            res = 0;
            mag = 0;
            fixed_seen++;
        end else begin
            dt = courant * (narrow_width >> 16) + ((courant * (narrow_width & 64'hFFFF)) >> 16);
            prod = 128'(dt) * 128'(mag);
            if (prod[127:64] != 0)
                res_mag = MAG_LIMIT;
            else if ((prod[63:0] >> FRAC_BITS) > MAG_LIMIT)
                res_mag = MAG_LIMIT;
            else
                res_mag = prod[63:0] >> FRAC_BITS;
            if (it.sign_value > 0)
                res = -longint'(res_mag);
            else if (it.sign_value < 0)
                res = res_mag;
            else
                res = 0;
            // below unit gradient the local term is negative
            if (root < UNIT_ONE)
                res = -res;
            if (mag > peak_magnitude)
                peak_magnitude = mag;
        end
        r.residual_update = res[DATA_WIDTH-1:0];
        r.local_magnitude = mag[MAG_WIDTH-1:0];
        r.running_max     = peak_magnitude[MAG_WIDTH-1:0];
        r.sweep_done      = it.last_node;
        node_results_due.insert(node_results_due.size(), r);
        upwind_acc = 0;
        narrow_width = WIDTH_INIT;
        if (it.last_node)
            peak_magnitude = 0;
    endtask

    // Driver: next item goes out once the current one is transferred
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_node(driven_item);
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    driven_item = pending_items.pop_front();
                    s_valid      <= 1'b1;
                    s_axis       <= driven_item.axis;
                    s_phi_center <= driven_item.phi_center;
                    s_phi_minus  <= driven_item.phi_minus;
                    s_phi_plus   <= driven_item.phi_plus;
                    s_gap_minus  <= driven_item.gap_minus;
                    s_gap_plus   <= driven_item.gap_plus;
                    s_cell_width <= driven_item.cell_width;
                    s_fixed_node <= driven_item.fixed_node;
                    s_sign_value <= driven_item.sign_value;
                    s_last_node  <= driven_item.last_node;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        node_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (node_results_due.size() == 0) begin
                    report_mismatch("result with nothing pending");
                end else begin
                    want = node_results_due.pop_front();
                    nodes_checked++;
                    if (m_sweep_done)
                        sweeps_seen++;
                    if (m_residual_update !== want.residual_update)
                        report_mismatch($sformatf("residual_update %0d want %0d",
                            m_residual_update, want.residual_update));
                    if (m_local_magnitude !== want.local_magnitude)
                        report_mismatch($sformatf("local_magnitude %0d want %0d",
                            m_local_magnitude, want.local_magnitude));
                    if (m_running_max !== want.running_max)
                        report_mismatch($sformatf("running_max %0d want %0d",
                            m_running_max, want.running_max));
                    if (m_sweep_done !== want.sweep_done)
                        report_mismatch($sformatf("sweep_done %0b want %0b",
                            m_sweep_done, want.sweep_done));
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic signed [DATA_WIDTH-1:0] rand_phi();
        case ($urandom_range(9))
            0, 1:    return DATA_WIDTH'($urandom);
            2:       return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(524288)) - 262144;
        endcase
    endfunction

    function automatic logic [MAG_WIDTH-1:0] rand_gap();
        case ($urandom_range(19))
            0:       return MAG_WIDTH'($urandom);
            1:       return MAG_WIDTH'($urandom_range(1));
            2:       return MAG_WIDTH'($urandom_range(255));
            default: return MAG_WIDTH'($urandom_range(131072, 16384));
        endcase
    endfunction

    function automatic axis_item_t rand_item(input logic [1:0] axis, input logic last);
        axis_item_t it;
        it.axis       = axis;
        it.phi_center = rand_phi();
        it.phi_minus  = ($urandom_range(3) == 0) ? rand_phi() : it.phi_center - rand_gap();
        it.phi_plus   = ($urandom_range(3) == 0) ? rand_phi() : it.phi_center + rand_gap();
        it.gap_minus  = rand_gap();
        it.gap_plus   = rand_gap();
        it.cell_width = rand_gap();
        it.fixed_node = ($urandom_range(4) == 0);
        it.sign_value = 2'($urandom_range(3));
        it.last_node  = last;
        return it;
    endfunction

    // One node: usually x, y, z in order; sometimes noise or a broken sequence
    task automatic queue_node();
        int shape;
        shape = $urandom_range(19);
        if (shape == 0)
            enqueue_item(rand_item(AXIS_NONE, 1'($urandom_range(1))));
        if (shape == 1) begin
            enqueue_item(rand_item(AXIS_Y, 1'b0));
        end else if (shape == 2) begin
            enqueue_item(rand_item(2'($urandom_range(1)), 1'b0));
            enqueue_item(rand_item(2'($urandom_range(1)), 1'b0));
            enqueue_item(rand_item(AXIS_X, 1'b0));
            enqueue_item(rand_item(AXIS_Y, 1'b0));
        end else begin
            enqueue_item(rand_item(AXIS_X, 1'b0));
            enqueue_item(rand_item(AXIS_Y, 1'b0));
        end
        enqueue_item(rand_item(AXIS_Z, $urandom_range(7) == 0));
    endtask

    // Hold until the block has drained, then let trailing work finish
    task automatic wait_idle();
        while (pending_items.size() > 0 || s_valid || node_results_due.size() > 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_courant(input logic [CFL_WIDTH-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        courant = value;
    endtask

    task automatic run_random(input int count);
        int start;
        start = items_sent + pending_items.size();
        while (items_sent + pending_items.size() - start < count)
            queue_node();
    endtask

    axis_item_t d;

    initial begin
        courant        = CFL_RESET;
        upwind_acc     = 0;
        narrow_width   = WIDTH_INIT;
        peak_magnitude = 0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes of the fields and each special case
        d = rand_item(AXIS_X, 1'b0);
        d.phi_center = 32'sh7FFFFFFF; d.phi_minus = 32'sh80000000; d.gap_minus = 31'd1;
        d.phi_plus = 32'sh80000000; d.gap_plus = 31'd1; d.cell_width = '1;
        enqueue_item(d);
        // zero gaps: one with a difference, one without
        d.phi_center = 32'sh00010000; d.phi_minus = '0; d.gap_minus = '0;
        d.phi_plus = 32'sh00010000; d.gap_plus = '0; d.cell_width = 31'd1;
        enqueue_item(d);
        d.axis = AXIS_Z; d.fixed_node = 1'b0; d.sign_value = SIGN_POS; d.last_node = 1'b0;
        enqueue_item(d);
        // flat node gives sqrt(sum) below one, negative sign code -2
        d = rand_item(AXIS_X, 1'b0);
        d.phi_center = 32'sh80000000; d.phi_minus = 32'sh80000000; d.phi_plus = 32'sh80000000;
        d.cell_width = 31'd32768;
        enqueue_item(d);
        d.axis = AXIS_Y; d.cell_width = 31'd65536;
        enqueue_item(d);
        d.axis = AXIS_Z; d.fixed_node = 1'b0; d.sign_value = 2'sb10;
        enqueue_item(d);
        // sign -1, sign 0, fixed node, last node
        d = rand_item(AXIS_Z, 1'b0); d.fixed_node = 1'b0; d.sign_value = 2'sb11;
        enqueue_item(d);
        d = rand_item(AXIS_Z, 1'b0); d.fixed_node = 1'b0; d.sign_value = SIGN_ZERO;
        enqueue_item(d);
        d = rand_item(AXIS_Z, 1'b0); d.fixed_node = 1'b1;
        enqueue_item(d);
        d = rand_item(AXIS_NONE, 1'b1);
        enqueue_item(d);
        d = rand_item(AXIS_Z, 1'b1); d.fixed_node = 1'b0; d.sign_value = SIGN_POS;
        enqueue_item(d);
        // unit slope on each axis item, both phi signs
        d = rand_item(AXIS_X, 1'b0);
        d.phi_center = 32'sh00020000; d.phi_minus = 32'sh00010000; d.gap_minus = 31'd65536;
        d.phi_plus = 32'sh00030000; d.gap_plus = 31'd65536;
        enqueue_item(d);
        d.axis = AXIS_Z; d.phi_center = -32'sh00020000; d.phi_minus = -32'sh00010000;
        d.phi_plus = -32'sh00030000; d.fixed_node = 1'b0; d.last_node = 1'b0;
        enqueue_item(d);
        wait_idle();

        // Courant extremes
        write_courant('1);
        repeat (3) queue_node();
        wait_idle();
        write_courant('0);
        repeat (3) queue_node();
        wait_idle();

        write_courant(CFL_WIDTH'($urandom_range(131071)));
        run_random(330);
        wait_idle();

        send_idle_pct = 82;
        recv_idle_pct = 6;
        write_courant(CFL_RESET);
        run_random(330);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_courant(CFL_WIDTH'($urandom_range(131071)));
        run_random(330);
        wait_idle();

        $display("%0d items sent, %0d node results checked (%0d fixed, %0d sweep ends)",
            items_sent, nodes_checked, fixed_seen, sweeps_seen);
        $display("Courant settings included zero, full scale and the reset value");
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
